@@ rtl/tcos_pkg.sv @@
// shared constants and controller/datapath interface types for the taylor cosine block
package tcos_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int MAX_TERMS_DEF = 32;

  localparam int ANGLE_W   = 32;
  localparam int COS_W     = 32;
  localparam int TERMS_W   = 6;
  localparam int TOL_W     = 25;
  localparam int TDATA_O_W = ((COS_W + TERMS_W + 7) / 8) * 8;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);

  localparam logic [63:0] TWO_PI_Q44 = 64'h0000_6487_ED51_10B4;
  localparam logic [ANGLE_W-1:0] TWO_PI_FIX =
    ANGLE_W'(((TWO_PI_Q44 >> (43 - FRAC_BITS)) + 64'd1) >> 1);

  localparam int RED_STEPS = 5;
  localparam int RED_CW    = $clog2(RED_STEPS);
  localparam logic [ANGLE_W-1:0] TWO_PI_TOP = TWO_PI_FIX << (RED_STEPS - 1);

  localparam int MAG_W = 32;
  localparam logic [MAG_W-1:0] ONE_FIX = MAG_W'(1) << FRAC_BITS;
  localparam int R_W   = $clog2(TWO_PI_FIX);
  localparam int X2_W  = 2 * R_W - FRAC_BITS;
  localparam int Q_W   = MAG_W + X2_W - FRAC_BITS;
  localparam int DIG_W = 4;
  localparam int NDIG  = (Q_W + DIG_W - 1) / DIG_W;
  localparam int DVD_W = NDIG * DIG_W;
  localparam int DIG_CW = $clog2(NDIG);

  typedef struct packed {
    logic load;
    logic red;
    logic sq;
    logic acc;
    logic mul;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic red_last;
    logic div_last;
    logic mag_le_tol;
    logic cap_hit;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/tcos_ctrl.sv @@
// sequencing state machine for the taylor cosine block
module tcos_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcos_pkg::stat_t st,
  output tcos_pkg::cmd_t  cmd
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_RED  = 3'd1;
  localparam logic [ST_W-1:0] S_SQ   = 3'd2;
  localparam logic [ST_W-1:0] S_CHK  = 3'd3;
  localparam logic [ST_W-1:0] S_MUL  = 3'd4;
  localparam logic [ST_W-1:0] S_DIV  = 3'd5;
  localparam logic [ST_W-1:0] S_DONE = 3'd6;

  logic [ST_W-1:0] state;
  logic [ST_W-1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_RED;
        end
      end
      S_RED: begin
        cmd.red = 1'b1;
        if (st.red_last) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (st.mag_le_tol || st.cap_hit) begin
          state_next = S_DONE;
        end else begin
          cmd.acc = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) begin
          state_next = S_CHK;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/tcos_dp.sv @@
// datapath: range reduction, squaring, term multiply, radix-16 divider, sum and output register
module tcos_dp #(
  parameter int MAX_TERMS = tcos_pkg::MAX_TERMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [tcos_pkg::ANGLE_W-1:0]     angle,
  input  logic                             cfg_valid,
  input  logic [tcos_pkg::TOL_W-1:0]       cfg_data,
  input  tcos_pkg::cmd_t                   cmd,
  output tcos_pkg::stat_t                  st,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tcos_pkg::TDATA_O_W-1:0]   m_tdata,
  output logic                             m_tuser
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int D_MAX = (2 * MAX_TERMS - 1) * (2 * MAX_TERMS);
  localparam int D_W   = $clog2(D_MAX + 1);
  localparam int RS_W  = D_W + tcos_pkg::DIG_W;
  localparam int NMUL  = 1 << tcos_pkg::DIG_W;
  localparam int SUM_W = tcos_pkg::MAG_W + $clog2(MAX_TERMS) + 1;
  localparam int P_W   = tcos_pkg::MAG_W + tcos_pkg::X2_W;
  localparam int SQ_W  = 2 * tcos_pkg::R_W;
  localparam int C2_W  = CNT_W + 1;
  localparam int PAD_W = tcos_pkg::TDATA_O_W - tcos_pkg::COS_W - tcos_pkg::TERMS_W;

  logic [tcos_pkg::TOL_W-1:0]   tol;
  logic [tcos_pkg::ANGLE_W-1:0] r;
  logic [tcos_pkg::ANGLE_W-1:0] tp_sh;
  logic [tcos_pkg::RED_CW-1:0]  red_cnt;
  logic [tcos_pkg::X2_W-1:0]    x2;
  logic [tcos_pkg::MAG_W-1:0]   mag;
  logic                         neg;
  logic signed [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]             count;
  logic [D_W-1:0]               d;
  logic [tcos_pkg::DVD_W-1:0]   dvd;
  logic [D_W-1:0]               rem;
  logic [tcos_pkg::MAG_W-1:0]   quo;
  logic [tcos_pkg::DIG_CW-1:0]  dig_cnt;
  logic [tcos_pkg::COS_W-1:0]   out_cos;
  logic [tcos_pkg::TERMS_W-1:0] out_cnt;
  logic                         out_flag;

  logic [tcos_pkg::ANGLE_W-1:0] abs_angle;
  logic [SQ_W-1:0]              sq_full;
  logic [P_W-1:0]               prod;
  logic [C2_W-1:0]              c2;
  logic [C2_W-1:0]              c2m1;
  logic [2*C2_W-1:0]            d_full;
  logic [RS_W-1:0]              rem_sh;
  logic [RS_W-1:0]              dmul [NMUL];
  logic [NMUL-1:1]              ge;
  logic [tcos_pkg::DIG_W-1:0]   digit;
  logic [RS_W-1:0]              rem_new;
  logic [tcos_pkg::MAG_W-1:0]   quo_next;
  logic signed [SUM_W-1:0]      mag_s;
  logic signed [SUM_W-1:0]      sat_max;
  logic signed [SUM_W-1:0]      sat_min;
  logic [tcos_pkg::COS_W-1:0]   cos_sat;

  assign abs_angle = angle[tcos_pkg::ANGLE_W-1] ? (tcos_pkg::ANGLE_W'(0) - angle) : angle;
  assign sq_full = SQ_W'(r[tcos_pkg::R_W-1:0]) * SQ_W'(r[tcos_pkg::R_W-1:0]);
  assign prod = P_W'(mag) * P_W'(x2);
  assign c2 = {count, 1'b0};
  assign c2m1 = c2 - C2_W'(1);
  assign d_full = (2*C2_W)'(c2) * (2*C2_W)'(c2m1);

  // one quotient digit per cycle, multiples of the divisor compared in parallel
  assign rem_sh = {rem, dvd[tcos_pkg::DVD_W-1 -: tcos_pkg::DIG_W]};

  always_comb begin
    for (int k = 0; k < NMUL; k++) begin
      dmul[k] = RS_W'(d * k);
    end
    for (int k = 1; k < NMUL; k++) begin
      ge[k] = (rem_sh >= dmul[k]);
    end
  end

  assign digit = tcos_pkg::DIG_W'($countones(ge));
  assign rem_new = rem_sh - dmul[digit];
  assign quo_next = {quo[tcos_pkg::MAG_W-tcos_pkg::DIG_W-1:0], digit};

  assign mag_s = $signed({{(SUM_W-tcos_pkg::MAG_W){1'b0}}, mag});
  assign sat_max = $signed({{(SUM_W-tcos_pkg::COS_W+1){1'b0}}, {(tcos_pkg::COS_W-1){1'b1}}});
  assign sat_min = $signed({{(SUM_W-tcos_pkg::COS_W+1){1'b1}}, {(tcos_pkg::COS_W-1){1'b0}}});

  always_comb begin
    if (sum > sat_max) begin
      cos_sat = sat_max[tcos_pkg::COS_W-1:0];
    end else if (sum < sat_min) begin
      cos_sat = sat_min[tcos_pkg::COS_W-1:0];
    end else begin
      cos_sat = sum[tcos_pkg::COS_W-1:0];
    end
  end

  assign st.red_last   = (red_cnt == tcos_pkg::RED_CW'(tcos_pkg::RED_STEPS - 1));
  assign st.div_last   = (dig_cnt == tcos_pkg::DIG_CW'(tcos_pkg::NDIG - 1));
  assign st.mag_le_tol = (mag <= tcos_pkg::MAG_W'(tol));
  assign st.cap_hit    = (count == CNT_W'(MAX_TERMS));
  assign st.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= tcos_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= abs_angle;
      tp_sh <= tcos_pkg::TWO_PI_TOP;
      red_cnt <= '0;
      mag <= tcos_pkg::ONE_FIX;
      neg <= 1'b0;
      sum <= '0;
      count <= '0;
    end
    if (cmd.red) begin
      if (r >= tp_sh) begin
        r <= r - tp_sh;
      end
      tp_sh <= tp_sh >> 1;
      red_cnt <= red_cnt + tcos_pkg::RED_CW'(1);
    end
    if (cmd.sq) begin
      x2 <= sq_full[SQ_W-1:tcos_pkg::FRAC_BITS];
    end
    if (cmd.acc) begin
      if (neg) begin
        sum <= sum - mag_s;
      end else begin
        sum <= sum + mag_s;
      end
      count <= count + CNT_W'(1);
      neg <= !neg;
    end
    if (cmd.mul) begin
      dvd <= tcos_pkg::DVD_W'(prod[P_W-1:tcos_pkg::FRAC_BITS]);
      d <= d_full[D_W-1:0];
      rem <= '0;
      quo <= '0;
      dig_cnt <= '0;
    end
    if (cmd.div) begin
      dvd <= dvd << tcos_pkg::DIG_W;
      rem <= rem_new[D_W-1:0];
      quo <= quo_next;
      dig_cnt <= dig_cnt + tcos_pkg::DIG_CW'(1);
      if (st.div_last) begin
        mag <= quo_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cos <= cos_sat;
      out_cnt <= tcos_pkg::TERMS_W'(count);
      out_flag <= !st.mag_le_tol;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_cnt, out_cos};
  assign m_tuser = out_flag;

  a_reduced_below_two_pi: assert property (@(posedge clk) disable iff (rst)
    cmd.sq |-> r < tcos_pkg::TWO_PI_FIX)
    else $error("reduced angle not below two pi");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    cmd.div |-> rem < d)
    else $error("divider remainder not below divisor");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwritten while still pending");

  a_term_index_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> (count != '0) && (count <= CNT_W'(MAX_TERMS)))
    else $error("term index out of range at multiply");

endmodule

@@ rtl/taylor_cosine_with_tolerance.sv @@
// top level of the taylor series cosine block with tolerance stop
// usage:
//   s_tvalid/s_tready/s_tdata carry one request: a signed Q8.24 angle.
//   m_tvalid/m_tready/m_tdata/m_tuser carry one result per request:
//   tdata holds the Q8.24 cosine and the count of summed terms,
//   tuser is high when the term cap was hit before the tolerance was met.
//   cfg_valid/cfg_ready/cfg_data write the unsigned Q1.24 tolerance; write only while idle.
// each request runs range reduction, one squaring step and then one pass per
//   term summed, at most MAX_TERMS; each term takes a check step, one multiply
//   and a radix-16 divide on the shared divider.
//   range reduction takes five compare-subtract steps.
// one request is in flight at a time; a new request is taken as soon as the
//   previous result sits in the output register, even if not yet taken.
// a stalled receiver holds the result; the block then waits before the
//   next result can be written.
// reset returns to idle with no result pending and tolerance 17.
module taylor_cosine_with_tolerance #(
  parameter int MAX_TERMS = tcos_pkg::MAX_TERMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tcos_pkg::ANGLE_W-1:0]     s_tdata,   // angle
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tcos_pkg::TDATA_O_W-1:0]   m_tdata,   // cosine, terms_summed, zero pad
  output logic                             m_tuser,   // not_converged
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcos_pkg::TOL_W-1:0]       cfg_data
);

  tcos_pkg::cmd_t  cmd;
  tcos_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  tcos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tcos_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .angle     (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the taylor series cosine block with tolerance stop
`timescale 1ns / 1ps

module tb;
  localparam int FRAC_BITS = tcos_pkg::FRAC_BITS;
  localparam int MAX_TERMS_DEF = tcos_pkg::MAX_TERMS_DEF;
  localparam int ANGLE_W = tcos_pkg::ANGLE_W;
  localparam int COS_W = tcos_pkg::COS_W;
  localparam int TERMS_W = tcos_pkg::TERMS_W;
  localparam int TOL_W = tcos_pkg::TOL_W;
  localparam int TDATA_O_W = tcos_pkg::TDATA_O_W;
  localparam logic [TOL_W-1:0] TOL_RESET = tcos_pkg::TOL_RESET;

  localparam logic [63:0] TWO_PI_WIDE = ((64'h6487ED5110B4 >> (43 - FRAC_BITS)) + 64'd1) >> 1;
  localparam logic [31:0] TWO_PI = TWO_PI_WIDE[31:0];
  localparam logic [TOL_W-1:0] TOL_ONE = TOL_W'(1) << FRAC_BITS;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 9 + 12 * MAX_TERMS_DEF + 10;

  typedef struct packed {
    logic [COS_W-1:0]   cosine;
    logic [TERMS_W-1:0] terms;
    logic               not_converged;
  } cosine_result_t;

  class cosine_scoreboard;
    cosine_result_t expected_cosines[$];
    logic [TOL_W-1:0] tol = TOL_RESET;
    int errors = 0;

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    function cosine_result_t predict_cosine(logic [ANGLE_W-1:0] angle);
      cosine_result_t res;
      logic [63:0] r, x2, mag, sum, i, count;
      logic neg;
      r = angle[31] ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
      r = r % TWO_PI_WIDE;
      x2 = (r * r) >> FRAC_BITS;
      mag = 64'd1 << FRAC_BITS;
      neg = 1'b0;
      sum = '0;
      count = '0;
      i = 64'd1;
      while (mag > {39'd0, tol} && count < MAX_TERMS_DEF) begin
        sum = neg ? sum - mag : sum + mag;
        count++;
        mag = (mag * x2) / ((((2 * i) - 1) * (2 * i)) << FRAC_BITS);
        neg = !neg;
        i++;
      end
      // saturate the wide sum to the signed 32-bit range
      if ($signed(sum) > 64'sh7FFF_FFFF) res.cosine = 32'h7FFF_FFFF;
      else if ($signed(sum) < -64'sh8000_0000) res.cosine = 32'h8000_0000;
      else res.cosine = sum[31:0];
      res.terms = count[TERMS_W-1:0];
      res.not_converged = (mag > {39'd0, tol});
      return res;
    endfunction

    function void note_angle(logic [ANGLE_W-1:0] angle);
      expected_cosines.push_back(predict_cosine(angle));
    endfunction

    task check_result(logic [TDATA_O_W-1:0] data, logic flag);
      cosine_result_t want;
      if (expected_cosines.size() == 0) begin
        report("result with no request pending", data, 0);
        return;
      end
      want = expected_cosines.pop_front();
      if (data[COS_W-1:0] !== want.cosine)
        report("cosine", data[COS_W-1:0], want.cosine);
      if (data[COS_W +: TERMS_W] !== want.terms)
        report("terms_summed", data[COS_W +: TERMS_W], want.terms);
      if (flag !== want.not_converged)
        report("not_converged", flag, want.not_converged);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ANGLE_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_O_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;
  logic steady = 1'b0;
  int idle_cycles = 0;
  cosine_scoreboard board;

  taylor_cosine_with_tolerance uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    m_tready <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    if (!steady && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 29);
    end
    s_tvalid <= 1'b1;
    s_tdata <= angle;
    do @(posedge clk); while (!s_tready);
    board.note_angle(angle);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (board.expected_cosines.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.tol = value;
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    logic [63:0] near;
    logic [ANGLE_W-1:0] mag;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: mag = $urandom_range(TWO_PI - 1);
      7, 8: begin
        // close to a whole number of turns
        near = $urandom_range(20) * TWO_PI_WIDE + 64'd8 - $urandom_range(16);
        mag = near[31:0];
      end
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic logic [TOL_W-1:0] random_tolerance();
    case ($urandom_range(2))
      0: return TOL_W'($urandom_range(1, TOL_ONE));
      1: return (TOL_W'(1) << $urandom_range(23)) + TOL_W'($urandom_range(3));
      default: return TOL_W'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_angle(random_angle());
  endtask

  logic [ANGLE_W-1:0] corner_angles[18];

  initial begin
    board = new();
    corner_angles = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      TWO_PI, TWO_PI - 1, TWO_PI + 1, -TWO_PI, TWO_PI >> 1,
                      -(TWO_PI >> 1), TWO_PI >> 2, 32'h0100_0000, 32'hFF00_0000,
                      32'(20 * TWO_PI_WIDE), 32'(20 * TWO_PI_WIDE - 1),
                      32'h5555_5555, 32'hAAAA_AAAA};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset tolerance
    foreach (corner_angles[k]) send_angle(corner_angles[k]);

    // zero tolerance: runs until a term truncates to zero
    write_tolerance('0);
    for (int k = 0; k < 8; k++) send_angle(corner_angles[k]);
    run_random(30);

    // tolerance of one: nothing is summed
    write_tolerance(TOL_ONE);
    for (int k = 0; k < 5; k++) send_angle(corner_angles[k]);
    run_random(25);

    write_tolerance(TOL_ONE - 1);
    for (int k = 0; k < 5; k++) send_angle(corner_angles[k]);
    run_random(25);

    // finest tolerance, with a stretch of back-to-back requests
    write_tolerance(TOL_W'(1));
    steady <= 1'b1;
    run_random(200);
    steady <= 1'b0;
    wait_for_results();
    run_random(100);

    for (int p = 0; p < 8; p++) begin
      write_tolerance(random_tolerance());
      run_random(145);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tcos_pkg.sv
rtl/tcos_ctrl.sv
rtl/tcos_dp.sv
rtl/taylor_cosine_with_tolerance.sv
tb/tb.sv
